// ===== design/swrl_pkg.sv =====
// Shared types and constants for the sliding-window rate limiter.
// Used by swrl_ctrl, swrl_dp and sliding_window_rate_limiter_top; no dependencies.
package swrl_pkg;

  localparam int unsigned MIN_W      = 6;
  localparam int unsigned LIM_W      = 33;
  localparam int unsigned WIN_W      = 6;
  localparam int unsigned STEP_W     = 32;
  localparam int unsigned TOT_W      = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 33;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned RES_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIMITING_ON  = 3'd0,
    CFG_RECORD_LIMIT = 3'd1,
    CFG_RECORD_WIN   = 3'd2,
    CFG_RECORD_STEP  = 3'd3,
    CFG_BYTE_LIMIT   = 3'd4,
    CFG_BYTE_WIN     = 3'd5,
    CFG_BYTE_STEP    = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SCAN,
    ST_FIN,
    ST_CRD,
    ST_CWR,
    ST_SWEEP
  } state_e;

  typedef struct packed {
    logic in_rdy;
    logic load_in;
    logic reduce;
    logic start_walk;
    logic rd_en;
    logic advance;
    logic commit_wr;
    logic sweep_clr;
    logic fin_load;
  } cmd_t;

  typedef struct packed {
    logic req_commit;
    logic cur_big;
    logic scan_done;
    logic sweep_last;
    logic out_free;
  } status_t;

endpackage

// ===== design/swrl_ctrl.sv =====
// Sequencer of the sliding-window rate limiter: walks checks and commits.
// Depends on swrl_pkg for the state, command and status types.
module swrl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  swrl_pkg::status_t status_i,
  output swrl_pkg::cmd_t    cmd_o
);

  swrl_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swrl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      swrl_pkg::ST_IDLE: begin
        if (s_tvalid_i) state_d = swrl_pkg::ST_REDUCE;
      end
      swrl_pkg::ST_REDUCE: begin
        if (!status_i.cur_big) begin
          state_d = status_i.req_commit ? swrl_pkg::ST_CRD : swrl_pkg::ST_SCAN;
        end
      end
      swrl_pkg::ST_SCAN: begin
        if (status_i.scan_done) state_d = swrl_pkg::ST_FIN;
      end
      swrl_pkg::ST_FIN: begin
        if (status_i.out_free) state_d = swrl_pkg::ST_IDLE;
      end
      swrl_pkg::ST_CRD:   state_d = swrl_pkg::ST_CWR;
      swrl_pkg::ST_CWR:   state_d = swrl_pkg::ST_SWEEP;
      swrl_pkg::ST_SWEEP: begin
        if (status_i.sweep_last) state_d = swrl_pkg::ST_IDLE;
      end
      default: state_d = swrl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      swrl_pkg::ST_IDLE: begin
        cmd_o.in_rdy  = 1'b1;
        cmd_o.load_in = s_tvalid_i;
      end
      swrl_pkg::ST_REDUCE: begin
        cmd_o.reduce     = status_i.cur_big;
        cmd_o.start_walk = ~status_i.cur_big;
      end
      swrl_pkg::ST_SCAN: begin
        cmd_o.rd_en   = ~status_i.scan_done;
        cmd_o.advance = ~status_i.scan_done;
      end
      swrl_pkg::ST_FIN: begin
        cmd_o.fin_load = status_i.out_free;
      end
      swrl_pkg::ST_CRD: begin
        cmd_o.rd_en = 1'b1;
      end
      swrl_pkg::ST_CWR: begin
        cmd_o.commit_wr = 1'b1;
        cmd_o.advance   = 1'b1;
      end
      swrl_pkg::ST_SWEEP: begin
        cmd_o.sweep_clr = 1'b1;
        cmd_o.advance   = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== design/swrl_dp.sv =====
// Datapath of the sliding-window rate limiter: registers, slot memories,
// window accumulators and result register. Depends on swrl_pkg.
module swrl_dp #(
  parameter int unsigned SLOT_COUNT  = 60,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [swrl_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [swrl_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic [swrl_pkg::IN_DATA_W-1:0]      s_tdata_i,
  input  logic                                s_tuser_i,
  input  logic                                m_tready_i,
  input  swrl_pkg::cmd_t                      cmd_i,
  output swrl_pkg::status_t                   status_o,
  output logic                                m_tvalid_o,
  output logic [swrl_pkg::OUT_DATA_W-1:0]     m_tdata_o
);

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int unsigned EXT_W =
    ((COUNT_WIDTH > swrl_pkg::STEP_W) ? COUNT_WIDTH : swrl_pkg::STEP_W) + 1;
  localparam int unsigned TW = swrl_pkg::TOT_W;
  localparam int unsigned SW = swrl_pkg::TOT_W + 1;
  localparam int unsigned MW = swrl_pkg::MIN_W;
  localparam logic [COUNT_WIDTH-1:0] SLOT_MAX = {COUNT_WIDTH{1'b1}};

  function automatic logic [CNT_W-1:0] clamp_win(input logic [swrl_pkg::WIN_W-1:0] win);
    if (win == '0) return CNT_W'(1);
    else if (int'(win) > SLOT_COUNT) return CNT_W'(SLOT_COUNT);
    else return CNT_W'(win);
  endfunction

  logic                          on_q;
  logic [swrl_pkg::LIM_W-1:0]    rec_lim_q, byt_lim_q;
  logic [swrl_pkg::WIN_W-1:0]    rec_win_q, byt_win_q;
  logic [swrl_pkg::STEP_W-1:0]   rec_step_q, byt_step_q;

  logic                          req_commit_q;
  logic [MW-1:0]                 cur_q;
  logic [IDX_W-1:0]              cur_idx_q, idx_q;
  logic [CNT_W-1:0]              k_q, k_rd_q;
  logic                          acc_vld_q;
  logic [TW-1:0]                 rec_tot_q, byt_tot_q;
  logic                          rec_fail_q, byt_fail_q;
  logic [SLOT_COUNT-1:0]         rec_vld_q, byt_vld_q;
  logic                          rec_rdv_q, byt_rdv_q;
  logic [COUNT_WIDTH-1:0]        rec_rd_q, byt_rd_q;
  logic                          out_vld_q;
  logic [swrl_pkg::RES_W-1:0]    out_data_q;

  logic [COUNT_WIDTH-1:0]        rec_mem [SLOT_COUNT];
  logic [COUNT_WIDTH-1:0]        byt_mem [SLOT_COUNT];

  logic                          rec_en, byt_en;
  logic [CNT_W-1:0]              rec_w, byt_w, w_max;
  logic [COUNT_WIDTH-1:0]        rec_v, byt_v, rec_new, byt_new;
  logic                          rec_ovf, byt_ovf;
  logic [SW-1:0]                 rec_sum, byt_sum, rec_fsum, byt_fsum;
  logic [TW-1:0]                 rec_sat, byt_sat, rec_ftot, byt_ftot;
  logic                          rec_ok, byt_ok, send_ok;

  always_comb begin
    rec_en   = ~rec_lim_q[swrl_pkg::LIM_W-1];
    byt_en   = ~byt_lim_q[swrl_pkg::LIM_W-1];
    rec_w    = clamp_win(rec_win_q);
    byt_w    = clamp_win(byt_win_q);
    w_max    = (rec_w > byt_w) ? rec_w : byt_w;

    rec_v    = rec_rdv_q ? rec_rd_q : '0;
    byt_v    = byt_rdv_q ? byt_rd_q : '0;
    rec_ovf  = (EXT_W'(rec_step_q) + EXT_W'(rec_v)) >= EXT_W'(SLOT_MAX);
    byt_ovf  = (EXT_W'(byt_step_q) + EXT_W'(byt_v)) >= EXT_W'(SLOT_MAX);
    rec_new  = rec_ovf ? SLOT_MAX : rec_v + COUNT_WIDTH'(rec_step_q);
    byt_new  = byt_ovf ? SLOT_MAX : byt_v + COUNT_WIDTH'(byt_step_q);

    rec_sum  = {1'b0, rec_tot_q} + SW'(rec_v);
    byt_sum  = {1'b0, byt_tot_q} + SW'(byt_v);
    rec_sat  = rec_sum[SW-1] ? '1 : rec_sum[TW-1:0];
    byt_sat  = byt_sum[SW-1] ? '1 : byt_sum[TW-1:0];

    rec_fsum = {1'b0, rec_tot_q} + SW'(rec_step_q);
    byt_fsum = {1'b0, byt_tot_q} + SW'(byt_step_q);
    rec_ftot = rec_fsum[SW-1] ? '1 : rec_fsum[TW-1:0];
    byt_ftot = byt_fsum[SW-1] ? '1 : byt_fsum[TW-1:0];

    rec_ok   = ~(on_q & rec_en) | (~rec_fail_q & (rec_ftot <= TW'(rec_lim_q)));
    byt_ok   = ~(on_q & byt_en) | (~byt_fail_q & (byt_ftot <= TW'(byt_lim_q)));
    send_ok  = ~on_q | (rec_ok & byt_ok);
  end

  always_comb begin
    status_o.req_commit = req_commit_q;
    status_o.cur_big    = int'(cur_q) >= SLOT_COUNT;
    status_o.scan_done  = (k_q == w_max);
    status_o.sweep_last = (k_q == CNT_W'(SLOT_COUNT - 1));
    status_o.out_free   = ~out_vld_q | m_tready_i;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q       <= 1'b0;
      rec_lim_q  <= '1;
      rec_win_q  <= swrl_pkg::WIN_W'(1);
      rec_step_q <= swrl_pkg::STEP_W'(1);
      byt_lim_q  <= '1;
      byt_win_q  <= swrl_pkg::WIN_W'(1);
      byt_step_q <= swrl_pkg::STEP_W'(1);
    end else if (cfg_we_i) begin
      case (swrl_pkg::cfg_reg_e'(cfg_addr_i))
        swrl_pkg::CFG_LIMITING_ON:  on_q       <= cfg_wdata_i[0];
        swrl_pkg::CFG_RECORD_LIMIT: rec_lim_q  <= cfg_wdata_i;
        swrl_pkg::CFG_RECORD_WIN:   rec_win_q  <= cfg_wdata_i[swrl_pkg::WIN_W-1:0];
        swrl_pkg::CFG_RECORD_STEP:  rec_step_q <= cfg_wdata_i[swrl_pkg::STEP_W-1:0];
        swrl_pkg::CFG_BYTE_LIMIT:   byt_lim_q  <= cfg_wdata_i;
        swrl_pkg::CFG_BYTE_WIN:     byt_win_q  <= cfg_wdata_i[swrl_pkg::WIN_W-1:0];
        swrl_pkg::CFG_BYTE_STEP:    byt_step_q <= cfg_wdata_i[swrl_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture, slot walk and window accumulation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_commit_q <= 1'b0;
      cur_q        <= '0;
      cur_idx_q    <= '0;
      idx_q        <= '0;
      k_q          <= '0;
      k_rd_q       <= '0;
      acc_vld_q    <= 1'b0;
      rec_tot_q    <= '0;
      byt_tot_q    <= '0;
      rec_fail_q   <= 1'b0;
      byt_fail_q   <= 1'b0;
      rec_rdv_q    <= 1'b0;
      byt_rdv_q    <= 1'b0;
    end else begin
      acc_vld_q <= cmd_i.rd_en & ~req_commit_q;
      if (cmd_i.load_in) begin
        req_commit_q <= s_tuser_i;
        cur_q        <= s_tdata_i[MW-1:0];
      end
      if (cmd_i.reduce) begin
        cur_q <= cur_q - MW'(SLOT_COUNT);
      end
      if (cmd_i.start_walk) begin
        cur_idx_q  <= IDX_W'(cur_q);
        idx_q      <= IDX_W'(cur_q);
        k_q        <= '0;
        rec_tot_q  <= '0;
        byt_tot_q  <= '0;
        rec_fail_q <= 1'b0;
        byt_fail_q <= 1'b0;
      end else begin
        if (cmd_i.advance) begin
          idx_q <= (idx_q == '0) ? IDX_W'(SLOT_COUNT - 1) : idx_q - 1'b1;
          k_q   <= k_q + 1'b1;
        end
        if (acc_vld_q && (k_rd_q < rec_w)) begin
          rec_tot_q <= rec_sat;
          if (rec_ovf) rec_fail_q <= 1'b1;
        end
        if (acc_vld_q && (k_rd_q < byt_w)) begin
          byt_tot_q <= byt_sat;
          if (byt_ovf) byt_fail_q <= 1'b1;
        end
      end
      if (cmd_i.rd_en) begin
        k_rd_q    <= k_q;
        rec_rdv_q <= rec_vld_q[idx_q];
        byt_rdv_q <= byt_vld_q[idx_q];
      end
    end
  end

  // per-slot valid bits: an invalid slot reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_vld_q <= '0;
      byt_vld_q <= '0;
    end else begin
      if (cmd_i.commit_wr) begin
        if (rec_en) rec_vld_q[cur_idx_q] <= 1'b1;
        if (byt_en) byt_vld_q[cur_idx_q] <= 1'b1;
      end
      if (cmd_i.sweep_clr) begin
        if (rec_en && (k_q >= rec_w)) rec_vld_q[idx_q] <= 1'b0;
        if (byt_en && (k_q >= byt_w)) byt_vld_q[idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_wr && rec_en) rec_mem[cur_idx_q] <= rec_new;
    if (cmd_i.rd_en) rec_rd_q <= rec_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_wr && byt_en) byt_mem[cur_idx_q] <= byt_new;
    if (cmd_i.rd_en) byt_rd_q <= byt_mem[idx_q];
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.fin_load) begin
      out_vld_q <= 1'b1;
    end else if (m_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_load) out_data_q <= {send_ok, byt_ok, rec_ok};
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = swrl_pkg::OUT_DATA_W'(out_data_q);

endmodule

// ===== design/sliding_window_rate_limiter_top.sv =====
// Check: walks the slots of the larger of the two windows, then gives a result.
// Commit: no result; updates its slot, then the next item is taken once the sweep ends.
// Either kind first takes SLOT_COUNT off an out-of-range minute until it is in range.
// A check holds in its last state while the previous result waits on m_axis_tready.
// Walk and sweep go one slot a cycle, from the single read port of each slot memory.
// Reset clears control, configuration and the per-slot valid bits at once.
module sliding_window_rate_limiter_top #(
  parameter int unsigned SLOT_COUNT  = 60,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [swrl_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [swrl_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [swrl_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // [5:0] minute_now
  input  logic                                s_axis_tuser,   // [0] req_type
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] record_pass, [1] byte_pass, [2] send_allowed
  output logic [swrl_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  swrl_pkg::cmd_t    cmd;
  swrl_pkg::status_t status;

  swrl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  swrl_dp #(
    .SLOT_COUNT  (SLOT_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tready_i  (m_axis_tready),
    .cmd_i       (cmd),
    .status_o    (status),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata)
  );

  assign s_axis_tready = cmd.in_rdy;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin_load |-> status.out_free)
    else $error("result register overwritten while pending");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.fin_load))
    else $error("result raised without a finished check");

  a_commit_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> !cmd.fin_load)
    else $error("commit produced a result");

  a_idle_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !(cmd.rd_en || cmd.commit_wr || cmd.sweep_clr))
    else $error("slot access while accepting");
`endif

endmodule

// ===== dv/swrl_verdict_checker.sv =====
// Verdict checker for the sliding-window rate limiter: mirrors the configuration and both
// per-minute slot rings, predicts the verdict of each check and compares it on m_axis.
// Depends on swrl_pkg for the register indexes and the port widths.
module swrl_verdict_checker #(
  parameter int unsigned SLOT_COUNT  = 60,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [swrl_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [swrl_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            req_valid_i,
  input  logic                            req_ready_i,
  input  logic [swrl_pkg::IN_DATA_W-1:0]  req_data_i,    // [5:0] minute_now
  input  logic                            req_commit_i,  // [0] req_type
  input  logic                            rsp_valid_i,
  input  logic                            rsp_ready_i,
  // [0] record_pass, [1] byte_pass, [2] send_allowed
  input  logic [swrl_pkg::OUT_DATA_W-1:0] rsp_data_i,
  output int unsigned                     verdicts_due_o,
  output int unsigned                     fail_count_o
);
  import swrl_pkg::*;

  localparam int unsigned REC = 0;
  localparam int unsigned BYT = 1;
  localparam logic [63:0] SLOT_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - COUNT_WIDTH);

  typedef struct packed {
    logic send_allowed;
    logic byte_pass;
    logic record_pass;
  } verdict_t;

  logic [COUNT_WIDTH-1:0] slot_cnt [2][SLOT_COUNT];
  logic                   limiting_on;
  logic [LIM_W-1:0]       limit_q  [2];
  logic [WIN_W-1:0]       window_q [2];
  logic [STEP_W-1:0]      step_q   [2];
  verdict_t               verdicts_due [$];

  function automatic int unsigned window_span(int unsigned l);
    if (window_q[l] == '0) return 1;
    if (window_q[l] > SLOT_COUNT) return SLOT_COUNT;
    return int'(window_q[l]);
  endfunction

  function automatic logic window_passes(int unsigned l, int unsigned cur);
    int unsigned span;
    int unsigned first;
    logic [63:0] slot;
    logic [64:0] total;
    span  = window_span(l);
    first = (cur + SLOT_COUNT - span + 1) % SLOT_COUNT;
    total = '0;
    for (int unsigned k = 0; k < span; k++) begin
      slot = 64'(slot_cnt[l][(first + k) % SLOT_COUNT]);
      if (64'(step_q[l]) >= SLOT_MAX - slot) return 1'b0;
      total = total + 65'(slot);
    end
    total = total + 65'(step_q[l]);
    return total <= 65'(limit_q[l]);
  endfunction

  task automatic add_to_slot(int unsigned l, int unsigned cur);
    int unsigned span;
    logic [63:0] slot;
    span = window_span(l);
    slot = 64'(slot_cnt[l][cur]);
    if (64'(step_q[l]) >= SLOT_MAX - slot) slot = SLOT_MAX;
    else slot = slot + 64'(step_q[l]);
    slot_cnt[l][cur] = slot[COUNT_WIDTH-1:0];
    for (int unsigned k = 1; k <= SLOT_COUNT - span; k++) begin
      slot_cnt[l][(cur + k) % SLOT_COUNT] = '0;
    end
  endtask

  task automatic compare_field(string field, logic want, logic got);
    if (want !== got) begin
      $display("%0t: %s expected %0b, got %0b", $time, field, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t    want;
    verdict_t    got;
    int unsigned cur;
    if (!rst_ni) begin
      limiting_on = 1'b0;
      for (int unsigned l = REC; l <= BYT; l++) begin
        limit_q[l]  = '1;
        window_q[l] = WIN_W'(1);
        step_q[l]   = STEP_W'(1);
        for (int unsigned s = 0; s < SLOT_COUNT; s++) slot_cnt[l][s] = '0;
      end
      verdicts_due.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          CFG_LIMITING_ON:  limiting_on   = cfg_wdata_i[0];
          CFG_RECORD_LIMIT: limit_q[REC]  = cfg_wdata_i[LIM_W-1:0];
          CFG_RECORD_WIN:   window_q[REC] = cfg_wdata_i[WIN_W-1:0];
          CFG_RECORD_STEP:  step_q[REC]   = cfg_wdata_i[STEP_W-1:0];
          CFG_BYTE_LIMIT:   limit_q[BYT]  = cfg_wdata_i[LIM_W-1:0];
          CFG_BYTE_WIN:     window_q[BYT] = cfg_wdata_i[WIN_W-1:0];
          CFG_BYTE_STEP:    step_q[BYT]   = cfg_wdata_i[STEP_W-1:0];
          default: ;
        endcase
      end

      if (rsp_valid_i && rsp_ready_i) begin
        got = verdict_t'(rsp_data_i[RES_W-1:0]);
        if (verdicts_due.size() == 0) begin
          $display("%0t: verdict %b arrived with none outstanding", $time, got);
          fail_count_o++;
        end else begin
          want = verdicts_due.pop_front();
          compare_field("record_pass", want.record_pass, got.record_pass);
          compare_field("byte_pass", want.byte_pass, got.byte_pass);
          compare_field("send_allowed", want.send_allowed, got.send_allowed);
        end
      end

      if (req_valid_i && req_ready_i) begin
        cur = int'(req_data_i[MIN_W-1:0]) % SLOT_COUNT;
        if (req_commit_i) begin
          for (int unsigned l = REC; l <= BYT; l++) begin
            if (!limit_q[l][LIM_W-1]) add_to_slot(l, cur);
          end
        end else begin
          want.record_pass = 1'b1;
          want.byte_pass   = 1'b1;
          if (limiting_on) begin
            if (!limit_q[REC][LIM_W-1]) want.record_pass = window_passes(REC, cur);
            if (!limit_q[BYT][LIM_W-1]) want.byte_pass = window_passes(BYT, cur);
          end
          want.send_allowed = !limiting_on || (want.record_pass && want.byte_pass);
          verdicts_due.push_back(want);
        end
      end
    end
    verdicts_due_o = verdicts_due.size();
  end

endmodule

// ===== dv/tb_sliding_window_rate_limiter_top.sv =====
// Testbench top for sliding_window_rate_limiter_top: drives configuration and check/commit
// traffic under several idle and stall mixes and gives the verdict.
// Depends on swrl_pkg, the design and swrl_verdict_checker.
module tb_sliding_window_rate_limiter_top;
  import swrl_pkg::*;

  localparam int unsigned SLOT_COUNT   = 60;
  localparam int unsigned DRAIN_CYCLES = 2 * SLOT_COUNT;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned PHASE_ITEMS  = 94;
  localparam logic        REQ_CHECK    = 1'b0;
  localparam logic        REQ_COMMIT   = 1'b1;
  localparam logic [LIM_W-1:0] LIMIT_OFF = '1;
  localparam logic [LIM_W-1:0] LIMIT_TOP = {1'b0, {STEP_W{1'b1}}};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // [5:0] minute_now
  logic                  s_axis_tuser;   // [0] req_type
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // [0] record_pass, [1] byte_pass, [2] send_allowed

  int unsigned verdicts_due;
  int unsigned fail_count;
  int unsigned src_idle_pct = 0;
  int unsigned stall_pct    = 0;
  int unsigned holds_asked  = 0;

  sliding_window_rate_limiter_top #(
    .SLOT_COUNT (SLOT_COUNT),
    .COUNT_WIDTH(32)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  swrl_verdict_checker #(
    .SLOT_COUNT (SLOT_COUNT),
    .COUNT_WIDTH(32)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_i   (s_axis_tready),
    .req_data_i    (s_axis_tdata),
    .req_commit_i  (s_axis_tuser),
    .rsp_valid_i   (m_axis_tvalid),
    .rsp_ready_i   (m_axis_tready),
    .rsp_data_i    (m_axis_tdata),
    .verdicts_due_o(verdicts_due),
    .fail_count_o  (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    int unsigned hold_left;
    int unsigned holds_seen;
    hold_left     = 0;
    holds_seen    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_seen != holds_asked) begin
        holds_seen = holds_asked;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
  endtask

  task automatic program_limiter(logic on,
                                 logic [LIM_W-1:0] rec_lim, logic [WIN_W-1:0] rec_win,
                                 logic [STEP_W-1:0] rec_step,
                                 logic [LIM_W-1:0] byte_lim, logic [WIN_W-1:0] byte_win,
                                 logic [STEP_W-1:0] byte_step);
    write_reg(CFG_LIMITING_ON, CFG_DATA_W'(on));
    write_reg(CFG_RECORD_LIMIT, CFG_DATA_W'(rec_lim));
    write_reg(CFG_RECORD_WIN, CFG_DATA_W'(rec_win));
    write_reg(CFG_RECORD_STEP, CFG_DATA_W'(rec_step));
    write_reg(CFG_BYTE_LIMIT, CFG_DATA_W'(byte_lim));
    write_reg(CFG_BYTE_WIN, CFG_DATA_W'(byte_win));
    write_reg(CFG_BYTE_STEP, CFG_DATA_W'(byte_step));
    cfg_we_i <= 1'b0;
  endtask

  // Entered and left at a falling edge; valid stays high after the transaction.
  task automatic send_item(logic commit, logic [MIN_W-1:0] minute);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'(minute);
    s_axis_tuser  <= commit;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    wait (verdicts_due == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [LIM_W-1:0] pick_limit();
    case ($urandom_range(9))
      0:       return LIMIT_OFF;
      1:       return {1'b1, STEP_W'($urandom)};
      2:       return LIMIT_TOP;
      3:       return '0;
      default: return LIM_W'($urandom_range(40));
    endcase
  endfunction

  function automatic logic [WIN_W-1:0] pick_window();
    if ($urandom_range(1) == 0) return WIN_W'($urandom_range(1, 6));
    return WIN_W'($urandom_range(63));
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return STEP_W'($urandom);
      default: return STEP_W'($urandom_range(1, 3));
    endcase
  endfunction

  // Mostly check-then-commit pairs on a slowly advancing minute, some lone items.
  task automatic random_traffic(int unsigned count);
    logic [MIN_W-1:0] minute;
    int unsigned      sent;
    minute = MIN_W'($urandom_range(SLOT_COUNT - 1));
    sent   = 0;
    while (sent < count) begin
      case ($urandom_range(19))
        0:          minute = MIN_W'($urandom);
        1, 2, 3, 4: minute = MIN_W'((int'(minute) + $urandom_range(1, 3)) % SLOT_COUNT);
        default: ;
      endcase
      if ($urandom_range(9) < 7) begin
        send_item(REQ_CHECK, minute);
        send_item(REQ_COMMIT, minute);
        sent += 2;
      end else begin
        send_item($urandom_range(1) ? REQ_COMMIT : REQ_CHECK, minute);
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = CFG_LIMITING_ON;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_CHECK;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: limiting off, both limiters disabled
    send_item(REQ_CHECK, 0);
    send_item(REQ_COMMIT, 0);
    send_item(REQ_CHECK, 63);

    // small record limit; byte limit one below all ones (still disabled), zero window and step
    settle();
    program_limiter(1'b1, LIM_W'(3), WIN_W'(2), STEP_W'(1), LIMIT_OFF - 1'b1, '0, '0);
    send_item(REQ_CHECK, 0);
    send_item(REQ_COMMIT, 0);
    send_item(REQ_COMMIT, 0);
    send_item(REQ_CHECK, 0);
    send_item(REQ_COMMIT, 0);
    send_item(REQ_CHECK, 0);
    send_item(REQ_CHECK, 1);
    send_item(REQ_COMMIT, 63);
    send_item(REQ_CHECK, 3);

    // saturating record step over an oversized window; zero byte limit
    settle();
    program_limiter(1'b1, LIMIT_TOP, WIN_W'(63), '1, '0, WIN_W'(SLOT_COUNT), '0);
    send_item(REQ_CHECK, 5);
    send_item(REQ_COMMIT, 5);
    send_item(REQ_CHECK, 59);
    send_item(REQ_COMMIT, 59);

    // commits still count while limiting is off
    settle();
    program_limiter(1'b0, LIMIT_TOP, WIN_W'(63), '0, LIM_W'(4), WIN_W'(SLOT_COUNT),
                    STEP_W'(5));
    send_item(REQ_COMMIT, 10);
    send_item(REQ_CHECK, 10);
    settle();
    program_limiter(1'b1, LIMIT_TOP, WIN_W'(63), '0, LIM_W'(4), WIN_W'(SLOT_COUNT),
                    STEP_W'(5));
    send_item(REQ_CHECK, 10);

    for (int round = 0; round < 2; round++) begin
      for (int mode = 0; mode < 4; mode++) begin
        settle();
        program_limiter($urandom_range(7) != 0, pick_limit(), pick_window(), pick_step(),
                        pick_limit(), pick_window(), pick_step());
        src_idle_pct = (mode == 1) ? 79 : (mode == 3) ? 21 : 0;
        stall_pct    = (mode == 2) ? 79 : (mode == 3) ? 21 : 0;
        if (round == 0 && mode == 0) begin
          random_traffic(30);
          holds_asked++;
          random_traffic(PHASE_ITEMS - 30);
        end else begin
          random_traffic(PHASE_ITEMS);
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
